// File: rtl/core/bpg_pkg.sv
package bpg_pkg;

  // nfa size
  localparam int STATE_COUNT = 256;
  localparam int VALUE_BITS  = 16;
  localparam int WORD_COUNT  = (STATE_COUNT + 63) / 64;
  localparam int VEC_BITS    = WORD_COUNT * 64;
  localparam int SN_BITS     = $clog2(STATE_COUNT);
  localparam int IDX_BITS    = SN_BITS + 1;

  // character mask store
  localparam int MASK_ROWS = 256;
  localparam int ROW_BITS  = 8;

  // queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // command codes
  localparam logic [2:0] CMD_MASK    = 3'd0;
  localparam logic [2:0] CMD_INITIAL = 3'd1;
  localparam logic [2:0] CMD_STAR    = 3'd2;
  localparam logic [2:0] CMD_ACCEPT  = 3'd3;
  localparam logic [2:0] CMD_VALUE   = 3'd4;
  localparam logic [2:0] CMD_BEGIN   = 3'd5;
  localparam logic [2:0] CMD_BYTE    = 3'd6;
  localparam logic [2:0] CMD_UNUSED  = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  char_code;
    logic [1:0]  word_index;
    logic [63:0] word_data;
    logic [7:0]  state_number;
    logic [15:0] pattern_value;
    logic        last;
  } bpg_item_t;

  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 full;
    logic                 empty;
  } bpg_qstat_t;

  typedef struct packed {
    logic clearing;
    logic idle;
  } bpg_status_t;

endpackage

// File: rtl/core/bit_parallel_glob_nfa.sv
// load, value and begin words are taken by the back end in its idle state; byte words
// also pass a step state (mask row read in idle, then shift-and update); the queue
// takes a word per cycle while full is low. A result reaches the ports after a begin
// or byte word with last: the value store is read and compared one entry per cycle
// reset (rst, synchronous): vectors clear at once; the mask store is swept one
// row per cycle over all 256 rows, with full held high during the sweep
module bit_parallel_glob_nfa import bpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         command,
  input  logic [7:0]         char_code,
  input  logic [1:0]         word_index,
  input  logic [63:0]        word_data,
  input  logic [7:0]         state_number,
  input  logic [15:0]        pattern_value,
  input  logic               last,
  output logic               empty,
  input  logic               pop,
  output logic signed [16:0] match_value
);

  bpg_qstat_t  qstat;
  bpg_status_t bstat;
  bpg_item_t   q_item;
  bpg_item_t   q_head;
  logic        q_push;
  logic        q_pop;

  // front end: accept and classify
  bpg_front u_front (
    .push, .full, .command, .char_code, .word_index, .word_data,
    .state_number, .pattern_value, .last, .qstat, .bstat, .q_push, .q_item
  );

  // word queue
  bpg_queue u_queue (
    .clk, .rst, .q_push, .q_item, .q_pop, .q_head, .qstat
  );

  // back end: nfa and result scan
  bpg_back u_back (
    .clk, .rst, .q_head, .qstat, .q_pop, .bstat, .empty, .pop, .match_value
  );

`ifndef SYNTHESIS
  a_clear_full: assert property (@(posedge clk) disable iff (rst) bstat.clearing |-> full)
    else $error("word accepted during mask sweep");
  a_qcount: assert property (@(posedge clk) disable iff (rst) 32'(qstat.count) <= QDEPTH)
    else $error("queue overfilled");
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst) q_pop |-> bstat.idle)
    else $error("queue popped while back end busy");
`endif

endmodule

// File: rtl/core/bpg_front.sv
module bpg_front import bpg_pkg::*; (
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command,
  input  logic [7:0]  char_code,
  input  logic [1:0]  word_index,
  input  logic [63:0] word_data,
  input  logic [7:0]  state_number,
  input  logic [15:0] pattern_value,
  input  logic        last,
  input  bpg_qstat_t  qstat,
  input  bpg_status_t bstat,
  output logic        q_push,
  output bpg_item_t   q_item
);

  logic word_ok;
  logic state_ok;
  logic keep;

  // classify: drop unused codes and out of range loads
  always_comb begin
    word_ok  = 32'(word_index) < WORD_COUNT;
    state_ok = 32'(state_number) < STATE_COUNT;
    unique case (command)
      CMD_MASK, CMD_INITIAL, CMD_STAR, CMD_ACCEPT: keep = word_ok;
      CMD_VALUE:                                   keep = state_ok;
      CMD_BEGIN, CMD_BYTE:                         keep = 1'b1;
      default:                                     keep = 1'b0;
    endcase
  end

  assign full   = qstat.full | bstat.clearing;
  assign q_push = push & ~full & keep;
  assign q_item = '{command: command, char_code: char_code, word_index: word_index,
                    word_data: word_data, state_number: state_number,
                    pattern_value: pattern_value, last: last};

endmodule

// File: rtl/core/bpg_queue.sv
module bpg_queue import bpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_push,
  input  bpg_item_t  q_item,
  input  logic       q_pop,
  output bpg_item_t  q_head,
  output bpg_qstat_t qstat
);

  bpg_item_t            slots [QDEPTH];
  logic [QPTR_BITS-1:0] wptr;
  logic [QPTR_BITS-1:0] rptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign do_push = q_push & (32'(count) < QDEPTH);
  assign do_pop  = q_pop & (count != '0);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      count <= count + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end
  end

  // word storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= q_item;
  end

  assign q_head      = slots[rptr];
  assign qstat.count = count;
  assign qstat.full  = 32'(count) >= QDEPTH;
  assign qstat.empty = count == '0;

endmodule

// File: rtl/core/bpg_back.sv
module bpg_back import bpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  bpg_item_t          q_head,
  input  bpg_qstat_t         qstat,
  output logic               q_pop,
  output bpg_status_t        bstat,
  output logic               empty,
  input  logic               pop,
  output logic signed [16:0] match_value
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]            state;
  logic [ROW_BITS-1:0]   clr_row;
  logic [VEC_BITS-1:0]   mask_mem [MASK_ROWS];
  logic [VEC_BITS-1:0]   mask_row;
  logic [VALUE_BITS-1:0] value_mem [STATE_COUNT];
  logic [VALUE_BITS-1:0] value_rd;
  logic [VEC_BITS-1:0]   active;
  logic [VEC_BITS-1:0]   initial_bits;
  logic [VEC_BITS-1:0]   star_bits;
  logic [VEC_BITS-1:0]   accept_bits;
  logic [VEC_BITS-1:0]   hits;
  logic [VEC_BITS-1:0]   active_next;
  logic                  step_last;
  logic [IDX_BITS-1:0]   idx;
  logic                  pend;
  logic                  hit_d;
  logic signed [16:0]    best;
  logic                  out_valid;
  logic                  take;
  logic                  out_free;
  logic                  out_load;

  assign take     = (state == ST_IDLE) & ~qstat.empty;
  assign q_pop    = take;
  assign out_free = ~out_valid | pop;
  assign out_load = (state == ST_OUT) & out_free;

  // shift-and update from the fetched mask row
  assign active_next = (active & star_bits) | ({active[VEC_BITS-2:0], 1'b0} & mask_row);

  // mask store: clearing sweep after reset, then word writes
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mask_mem[clr_row] <= '0;
    end else if (take && q_head.command == CMD_MASK) begin
      mask_mem[q_head.char_code][q_head.word_index*64 +: 64] <= q_head.word_data;
    end
    if (take && q_head.command == CMD_BYTE) mask_row <= mask_mem[q_head.char_code];
  end

  // accept value store, read one entry per scan cycle
  always_ff @(posedge clk) begin
    if (take && q_head.command == CMD_VALUE)
      value_mem[q_head.state_number[SN_BITS-1:0]] <= q_head.pattern_value[VALUE_BITS-1:0];
    if (state == ST_SCAN && 32'(idx) < STATE_COUNT)
      value_rd <= value_mem[idx[SN_BITS-1:0]];
  end

  // control and nfa vectors
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_row      <= '0;
      active       <= '0;
      initial_bits <= '0;
      star_bits    <= '0;
      accept_bits  <= '0;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
    end else begin
      out_valid <= out_load | (out_valid & ~pop);
      unique case (state)
        ST_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_BITS'(MASK_ROWS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (take) begin
            idx  <= '0;
            pend <= 1'b0;
            best <= -17'sd1;
            unique case (q_head.command)
              CMD_INITIAL: initial_bits[q_head.word_index*64 +: 64] <= q_head.word_data;
              CMD_STAR:    star_bits[q_head.word_index*64 +: 64]    <= q_head.word_data;
              CMD_ACCEPT:  accept_bits[q_head.word_index*64 +: 64]  <= q_head.word_data;
              CMD_BEGIN: begin
                active <= initial_bits;
                hits   <= initial_bits & accept_bits;
                if (q_head.last) state <= ST_SCAN;
              end
              CMD_BYTE: begin
                step_last <= q_head.last;
                state     <= ST_STEP;
              end
              default: ;
            endcase
          end
        end
        ST_STEP: begin
          active <= active_next;
          hits   <= active_next & accept_bits;
          state  <= step_last ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          // one state per cycle, compared in the cycle after its read
          if (pend && hit_d && ($signed({1'b0, value_rd}) > best))
            best <= 17'($signed({1'b0, value_rd}));
          if (32'(idx) < STATE_COUNT) begin
            hit_d <= hits[idx[SN_BITS-1:0]];
            pend  <= 1'b1;
            idx   <= idx + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            match_value <= best;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign empty          = ~out_valid;
  assign bstat.clearing = state == ST_CLEAR;
  assign bstat.idle     = state == ST_IDLE;

endmodule

// File: bench/bit_parallel_glob_nfa_test.sv
`timescale 1ns / 100ps

module bit_parallel_glob_nfa_test;
  import bpg_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_WORDS = 600;
  localparam int ITEM_BITS = $bits(bpg_item_t);

  // predicted nfa state and the queue of expected match values
  class match_scoreboard;
    logic [63:0] active[WORD_COUNT];
    logic [63:0] init_vec[WORD_COUNT];
    logic [63:0] star_vec[WORD_COUNT];
    logic [63:0] accept_vec[WORD_COUNT];
    logic [63:0] masks[MASK_ROWS][WORD_COUNT];
    logic [VALUE_BITS-1:0] values[STATE_COUNT];
    logic signed [16:0] awaited[$];
    int mismatches;
    int matched;
    int hits;

    function new();
      for (int w = 0; w < WORD_COUNT; w++) begin
        active[w] = '0;
        init_vec[w] = '0;
        star_vec[w] = '0;
        accept_vec[w] = '0;
        for (int r = 0; r < MASK_ROWS; r++) masks[r][w] = '0;
      end
      for (int s = 0; s < STATE_COUNT; s++) values[s] = '0;
      mismatches = 0;
      matched = 0;
      hits = 0;
    endfunction

    // one shift-and step for a string byte
    function void step_byte(logic [7:0] c);
      logic [63:0] old;
      logic [63:0] shifted;
      logic carry;
      carry = 1'b0;
      for (int w = 0; w < WORD_COUNT; w++) begin
        old = active[w];
        shifted = {old[62:0], carry};
        active[w] = (old & star_vec[w]) | (shifted & masks[c][w]);
        carry = old[63];
      end
    endfunction

    // largest value among active accept states, -1 if none
    function logic signed [16:0] best_match();
      int best;
      int v;
      logic [63:0] live;
      best = -1;
      for (int w = 0; w < WORD_COUNT; w++) begin
        live = active[w] & accept_vec[w];
        for (int b = 0; b < 64; b++) begin
          if (live[b] && (w * 64 + b) < STATE_COUNT) begin
            v = values[w * 64 + b];
            if (v > best) best = v;
          end
        end
      end
      return best[16:0];
    endfunction

    function void note_word(bpg_item_t it);
      case (it.command)
        CMD_MASK:    masks[it.char_code][it.word_index] = it.word_data;
        CMD_INITIAL: init_vec[it.word_index] = it.word_data;
        CMD_STAR:    star_vec[it.word_index] = it.word_data;
        CMD_ACCEPT:  accept_vec[it.word_index] = it.word_data;
        CMD_VALUE:   values[it.state_number] = it.pattern_value[VALUE_BITS-1:0];
        CMD_BEGIN: begin
          for (int w = 0; w < WORD_COUNT; w++) active[w] = init_vec[w];
          if (it.last) awaited = {awaited, best_match()};
        end
        CMD_BYTE: begin
          step_byte(it.char_code);
          if (it.last) awaited = {awaited, best_match()};
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [16:0] got);
      logic signed [16:0] want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: match_value=%0d", got);
        return;
      end
      want = awaited.pop_front();
      matched++;
      if (want != -17'sd1) hits++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on match_value: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic [2:0] command = '0;
  logic [7:0] char_code = '0;
  logic [1:0] word_index = '0;
  logic [63:0] word_data = '0;
  logic [7:0] state_number = '0;
  logic [15:0] pattern_value = '0;
  logic last = 1'b0;
  logic signed [16:0] match_value;

  match_scoreboard sb = new();
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;
  int sent = 0;

  bit_parallel_glob_nfa u_top (
    .clk, .rst, .push, .full, .command, .char_code, .word_index, .word_data,
    .state_number, .pattern_value, .last, .empty, .pop, .match_value
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: check accepted result words, random stalls
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(match_value);
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(bpg_item_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    command <= it.command;
    char_code <= it.char_code;
    word_index <= it.word_index;
    word_data <= it.word_data;
    state_number <= it.state_number;
    pattern_value <= it.pattern_value;
    last <= it.last;
    do @(posedge clk); while (full);
    sb.note_word(it);
    sent++;
  endtask

  task automatic send_cmd(logic [2:0] cmd, logic [7:0] c, logic [1:0] wi, logic [63:0] wd,
                          logic [7:0] sn, logic [15:0] pv, logic lst);
    bpg_item_t it;
    it.command = cmd;
    it.char_code = c;
    it.word_index = wi;
    it.word_data = wd;
    it.state_number = sn;
    it.pattern_value = pv;
    it.last = lst;
    send_word(it);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // string bytes mostly from a small alphabet, sometimes the extremes
  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'h61 + 8'($urandom_range(7));
    endcase
  endfunction

  initial begin
    int len;
    int kind;
    int phase_len;
    bit drained;
    bpg_item_t noise;
    phase_len = RANDOM_WORDS / 3;
    drained = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // every accept value written before any result can read it
    for (int s = 0; s < STATE_COUNT; s++)
      send_cmd(CMD_VALUE, '0, '0, '0, 8'(s), 16'($urandom), 1'b0);
    for (int c = 0; c < 8; c++)
      for (int w = 0; w < WORD_COUNT; w++)
        send_cmd(CMD_MASK, 8'h61 + 8'(c), 2'(w), rand64() | rand64(), '0, '0, 1'b0);

    // directed: byte before any begin, empty strings, extremes, unused command
    send_cmd(CMD_BYTE, 8'h61, '0, '0, '0, '0, 1'b1);
    send_cmd(CMD_BEGIN, '0, '0, '0, '0, '0, 1'b1);
    send_cmd(CMD_VALUE, '0, '0, '0, 8'd0, 16'hFFFF, 1'b1);
    send_cmd(CMD_VALUE, '0, '0, '0, 8'd255, 16'h0000, 1'b0);
    send_cmd(CMD_INITIAL, '0, 2'd0, 64'h1, '0, '0, 1'b0);
    send_cmd(CMD_INITIAL, '0, 2'd3, '1, '0, '0, 1'b1);
    send_cmd(CMD_ACCEPT, '0, 2'd0, 64'h1, '0, '0, 1'b0);
    send_cmd(CMD_ACCEPT, '0, 2'd3, 64'h8000_0000_0000_0000, '0, '0, 1'b0);
    send_cmd(CMD_BEGIN, '0, '0, '0, '0, '0, 1'b1);
    send_cmd(CMD_STAR, '0, 2'd0, '1, '0, '0, 1'b0);
    send_cmd(CMD_MASK, 8'd0, 2'd1, '1, '0, '0, 1'b0);
    send_cmd(CMD_MASK, 8'd255, 2'd2, '1, '0, '0, 1'b1);
    send_cmd(CMD_BEGIN, '0, '0, '0, '0, '0, 1'b0);
    send_cmd(CMD_BYTE, 8'd0, '0, '0, '0, '0, 1'b0);
    send_cmd(CMD_BYTE, 8'd255, '0, '0, '0, '0, 1'b1);
    send_cmd(CMD_UNUSED, '1, '1, '1, '1, '1, 1'b1);
    send_cmd(CMD_STAR, '0, 2'd0, '0, '0, '0, 1'b0);
    send_cmd(CMD_BYTE, 8'h62, '0, '0, '0, '0, 1'b1);
    send_cmd(CMD_ACCEPT, '0, 2'd1, '1, '0, '0, 1'b0);
    send_cmd(CMD_ACCEPT, '0, 2'd2, '1, '0, '0, 1'b0);
    send_cmd(CMD_BEGIN, '0, '0, '0, '0, '0, 1'b1);

    // random: mostly begin/bytes/last strings, then loads, then noise
    for (int n = 0; n < RANDOM_WORDS; ) begin
      if (n < phase_len) begin
        send_idle = 15; recv_idle = 62;
      end else if (n < 2 * phase_len) begin
        send_idle = 62; recv_idle = 15;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      if (!drained && n >= phase_len + 10) begin
        // hold off until the block has drained
        drained = 1'b1;
        push <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
      end
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = $urandom_range(5);
        send_cmd(CMD_BEGIN, 8'($urandom), 2'($urandom), rand64(), 8'($urandom),
                 16'($urandom), len == 0);
        n++;
        for (int k = 1; k <= len; k++) begin
          send_cmd(CMD_BYTE, pick_char(), 2'($urandom), rand64(), 8'($urandom),
                   16'($urandom), k == len);
          n++;
        end
      end else if (kind < 85) begin
        case ($urandom_range(4))
          0: send_cmd(CMD_MASK, pick_char(), 2'($urandom), rand64() | rand64(), '0, '0,
                      1'($urandom));
          1: send_cmd(CMD_INITIAL, '0, 2'($urandom), rand64(), '0, '0, 1'($urandom));
          2: send_cmd(CMD_STAR, '0, 2'($urandom), rand64() & rand64(), '0, '0, 1'($urandom));
          3: send_cmd(CMD_ACCEPT, '0, 2'($urandom), rand64(), '0, '0, 1'($urandom));
          default: send_cmd(CMD_VALUE, '0, '0, '0, 8'($urandom), 16'($urandom),
                            1'($urandom));
        endcase
        n++;
      end else begin
        noise = bpg_item_t'(ITEM_BITS'({$urandom, $urandom, $urandom, $urandom}));
        send_word(noise);
        if (noise.command != CMD_UNUSED) n++;
      end
    end
    push <= 1'b0;

    // drain, then allow for the end-of-string scan
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (STATE_COUNT + 20) @(posedge clk);

    $display("%0d words sent, %0d match results checked (%0d with a match)",
             sent, sb.matched, sb.hits);
    $display("covered loads, empty strings, bytes without begin and the unused command");
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.awaited.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
